// ===== src/cttr_pkg.sv =====
// ----------------------------------------------------------------------------
// cttr_pkg: shared types and codes for the cyclic tour table
// Operation codes and the one-hot sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package cttr_pkg;

  // operation codes of an input item (code 3 behaves as a query)
  localparam logic [1:0] OP_REVERSE = 2'd0;
  localparam logic [1:0] OP_SWAP    = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  // sequencer states, one-hot
  typedef enum logic [15:0] {
    S_CLEAR  = 16'b0000_0000_0000_0001,
    S_IDLE   = 16'b0000_0000_0000_0010,
    S_POS    = 16'b0000_0000_0000_0100,
    S_REV_A  = 16'b0000_0000_0000_1000,
    S_REV_B  = 16'b0000_0000_0001_0000,
    S_REV_C  = 16'b0000_0000_0010_0000,
    S_REV_D  = 16'b0000_0000_0100_0000,
    S_SW_LEN = 16'b0000_0000_1000_0000,
    S_SW_CHK = 16'b0000_0001_0000_0000,
    S_CP_SEL = 16'b0000_0010_0000_0000,
    S_CP_RD  = 16'b0000_0100_0000_0000,
    S_CP_WR  = 16'b0000_1000_0000_0000,
    S_RB_RD  = 16'b0001_0000_0000_0000,
    S_RB_WR  = 16'b0010_0000_0000_0000,
    S_NB     = 16'b0100_0000_0000_0000,
    S_OUT    = 16'b1000_0000_0000_0000
  } state_t;

endpackage

`default_nettype wire

// ===== src/cyclic_tour_table_with_reversal_top.sv =====
// ----------------------------------------------------------------------------
// cyclic_tour_table_with_reversal_top: cyclic tour with reverse and swap
// Order table and inverse position table in synchronous RAMs, driven by a
// one-hot sequencer that reads, modifies and writes back one entry at a time.
// ----------------------------------------------------------------------------
// After reset, and after every write of cfg_tour_length, the block runs a
// clearing pass over all MAX_VERTICES entries that writes identity into both
// tables; in_ready stays low meanwhile. An item is transferred, the four vertex
// positions are fetched, then the operation runs, the positions are fetched a
// second time after a reverse or swap, the neighbors are read and the output
// register is loaded. An item with a bad vertex goes straight to the output
// register. A reverse exchanges gap/2+1 pairs (one pair for a negative gap),
// each with two reads and two writes on the order table, which has one read
// and one write port. A swap copies the four segments into the rebuild buffer
// and writes them back, a read and a write per vertex in each sweep, bounded
// by the one read port of each RAM. A malformed swap skips both sweeps. The
// next item is taken while a finished result still waits in the output
// register; a stalled output adds its stall to the item after it.
// ----------------------------------------------------------------------------
`default_nettype none

module cyclic_tour_table_with_reversal_top
  import cttr_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  wire               clk,
  input  wire               rst_n,
  // configuration
  input  wire               cfg_wr_en,
  input  wire        [10:0] cfg_tour_length,
  // input channel
  input  wire               in_valid,
  output logic              in_ready,
  input  wire        [1:0]  in_operation,
  input  wire        [9:0]  in_vert_a,
  input  wire        [9:0]  in_vert_b,
  input  wire        [9:0]  in_vert_c,
  input  wire        [9:0]  in_vert_d,
  // result channel
  output logic              out_valid,
  input  wire               out_ready,
  output logic       [9:0]  out_position_a,
  output logic       [9:0]  out_successor_a,
  output logic       [9:0]  out_predecessor_a,
  output logic signed [10:0] out_gap_bc,
  output logic              out_a_between,
  output logic              out_bad_vertex
);

  localparam int PW      = $clog2(MAX_VERTICES);
  localparam int LW      = PW + 1;
  localparam int RST_LEN = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;

  // cyclic helpers on positions
  function automatic logic [PW-1:0] f_fwd(input logic [PW-1:0] p, input logic [LW-1:0] n);
    logic [LW-1:0] s;
    s = LW'(p) + LW'(1);
    return (s >= n) ? '0 : s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] f_bwd(input logic [PW-1:0] p, input logic [LW-1:0] n);
    logic [LW-1:0] m;
    m = n - LW'(1);
    return (p == '0) ? m[PW-1:0] : p - PW'(1);
  endfunction

  function automatic logic [LW-1:0] f_span(input logic [PW-1:0] p, input logic [PW-1:0] q,
                                           input logic [LW-1:0] n);
    return (q >= p) ? LW'(q - p) : n - LW'(p - q);
  endfunction

  function automatic int f_gap(input logic [PW-1:0] p, input logic [PW-1:0] q,
                               input logic [LW-1:0] n);
    return (p > q) ? (int'(n) - (int'(p) - int'(q) + 1)) : (int'(q) - int'(p) - 1);
  endfunction

  // memories
  logic [PW-1:0] ord_mem [MAX_VERTICES];
  logic [PW-1:0] pos_mem [MAX_VERTICES];
  logic [PW-1:0] rbf_mem [MAX_VERTICES];

  logic [PW-1:0] ord_raddr, ord_waddr, ord_wdata, ord_q;
  logic [PW-1:0] pos_raddr, pos_waddr, pos_wdata, pos_q;
  logic [PW-1:0] rbf_raddr, rbf_waddr, rbf_wdata, rbf_q;
  logic          ord_we, pos_we, rbf_we;

  // control and working registers
  state_t         state_r;
  logic [LW-1:0]  n_r;
  logic [LW-1:0]  cnt_r;
  logic [LW-1:0]  k_r;
  logic           pass_r;
  logic [2:0]     run_r;
  logic [1:0]     op_r;
  logic [9:0]     va_r, vb_r, vc_r, vd_r;
  logic           bad_r;
  logic [PW-1:0]  p_r [4];
  logic [PW-1:0]  rp_r, rq_r, x_r, src_r;
  logic [PW-1:0]  succ_r, pred_r;
  logic [PW-1:0]  start_r [4];
  logic [LW-1:0]  len_r [4];
  logic           out_valid_r;

  logic [31:0]    cfg_len;
  logic [LW-1:0]  n_nxt;
  logic           in_bad;
  logic           out_load;
  int             gap_pos;
  logic [LW+1:0]  len_sum;

  // clamp of a written length
  always_comb begin
    cfg_len = 32'(cfg_tour_length);
    if (cfg_len == 32'd0) begin
      cfg_len = 32'd1;
    end
    if (cfg_len > 32'(MAX_VERTICES)) begin
      cfg_len = 32'(MAX_VERTICES);
    end
    n_nxt = LW'(cfg_len);
  end

  // range check on the incoming vertices
  assign in_bad = (32'(in_vert_a) >= 32'(n_r)) || (32'(in_vert_b) >= 32'(n_r)) ||
                  (32'(in_vert_c) >= 32'(n_r)) ||
                  ((in_operation == OP_SWAP) && (32'(in_vert_d) >= 32'(n_r)));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign gap_pos   = f_gap(p_r[1], p_r[2], n_r);
  assign len_sum   = (LW+2)'(len_r[0]) + (LW+2)'(len_r[1]) +
                     (LW+2)'(len_r[2]) + (LW+2)'(len_r[3]);

  // memory port control
  always_comb begin
    ord_raddr = '0;
    ord_we    = 1'b0;
    ord_waddr = '0;
    ord_wdata = '0;
    pos_raddr = '0;
    pos_we    = 1'b0;
    pos_waddr = '0;
    pos_wdata = '0;
    rbf_raddr = cnt_r[PW-1:0];
    rbf_we    = 1'b0;
    rbf_waddr = k_r[PW-1:0];
    rbf_wdata = ord_q;
    case (state_r)
      S_CLEAR: begin
        ord_we    = 1'b1;
        ord_waddr = cnt_r[PW-1:0];
        ord_wdata = cnt_r[PW-1:0];
        pos_we    = 1'b1;
        pos_waddr = cnt_r[PW-1:0];
        pos_wdata = cnt_r[PW-1:0];
      end
      S_POS: begin
        case (cnt_r[1:0])
          2'd0:    pos_raddr = PW'(va_r);
          2'd1:    pos_raddr = PW'(vb_r);
          2'd2:    pos_raddr = PW'(vc_r);
          default: pos_raddr = PW'(vd_r);
        endcase
      end
      S_REV_A: ord_raddr = rp_r;
      S_REV_B: ord_raddr = rq_r;
      S_REV_C: begin
        ord_we    = 1'b1;
        ord_waddr = rp_r;
        ord_wdata = ord_q;
        pos_we    = 1'b1;
        pos_waddr = ord_q;
        pos_wdata = rp_r;
      end
      S_REV_D: begin
        ord_we    = 1'b1;
        ord_waddr = rq_r;
        ord_wdata = x_r;
        pos_we    = 1'b1;
        pos_waddr = x_r;
        pos_wdata = rq_r;
      end
      S_CP_RD: ord_raddr = src_r;
      S_CP_WR: rbf_we = 1'b1;
      S_RB_WR: begin
        ord_we    = 1'b1;
        ord_waddr = cnt_r[PW-1:0];
        ord_wdata = rbf_q;
        pos_we    = 1'b1;
        pos_waddr = rbf_q;
        pos_wdata = cnt_r[PW-1:0];
      end
      S_NB: begin
        ord_raddr = (cnt_r == '0) ? f_fwd(p_r[0], n_r) : f_bwd(p_r[0], n_r);
      end
      default: begin
      end
    endcase
  end

  // synchronous RAMs, one read and one write port each
  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_q <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (rbf_we) begin
      rbf_mem[rbf_waddr] <= rbf_wdata;
    end
    rbf_q <= rbf_mem[rbf_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      n_r         <= LW'(RST_LEN);
      cnt_r       <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (cnt_r == LW'(MAX_VERTICES - 1)) begin
            state_r <= S_IDLE;
          end
          cnt_r <= cnt_r + LW'(1);
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= in_operation;
            va_r   <= in_vert_a;
            vb_r   <= in_vert_b;
            vc_r   <= in_vert_c;
            vd_r   <= in_vert_d;
            bad_r  <= in_bad;
            cnt_r  <= '0;
            pass_r <= 1'b0;
            state_r <= in_bad ? S_OUT : S_POS;
          end
        end
        S_POS: begin
          // address goes out at count 0..3, data lands one count later
          if (cnt_r != '0) begin
            p_r[cnt_r[1:0] - 2'd1] <= pos_q;
          end
          cnt_r <= cnt_r + LW'(1);
          if (cnt_r == LW'(4)) begin
            cnt_r <= '0;
            if (pass_r) begin
              state_r <= S_NB;
            end else if (op_r == OP_REVERSE) begin
              rp_r    <= p_r[1];
              rq_r    <= p_r[2];
              cnt_r   <= (gap_pos < 0) ? LW'(1) : LW'((gap_pos >>> 1) + 1);
              state_r <= S_REV_A;
            end else if (op_r == OP_SWAP) begin
              state_r <= S_SW_LEN;
            end else begin
              state_r <= S_NB;
            end
          end
        end
        S_REV_A: state_r <= S_REV_B;
        S_REV_B: begin
          x_r     <= ord_q;
          state_r <= S_REV_C;
        end
        S_REV_C: state_r <= S_REV_D;
        S_REV_D: begin
          rp_r  <= f_fwd(rp_r, n_r);
          rq_r  <= f_bwd(rq_r, n_r);
          cnt_r <= cnt_r - LW'(1);
          if (cnt_r == LW'(1)) begin
            cnt_r   <= '0;
            pass_r  <= 1'b1;
            state_r <= S_POS;
          end else begin
            state_r <= S_REV_A;
          end
        end
        S_SW_LEN: begin
          // runs: second segment, middle, first segment, final stretch
          start_r[0] <= p_r[2];
          start_r[1] <= f_fwd(p_r[1], n_r);
          start_r[2] <= p_r[0];
          start_r[3] <= f_fwd(p_r[3], n_r);
          len_r[0]   <= f_span(p_r[2], p_r[3], n_r) + LW'(1);
          len_r[1]   <= f_span(f_fwd(p_r[1], n_r), p_r[2], n_r);
          len_r[2]   <= f_span(p_r[0], p_r[1], n_r) + LW'(1);
          len_r[3]   <= f_span(f_fwd(p_r[3], n_r), p_r[0], n_r);
          state_r    <= S_SW_CHK;
        end
        S_SW_CHK: begin
          k_r   <= '0;
          run_r <= '0;
          cnt_r <= '0;
          if (len_sum == (LW+2)'(n_r)) begin
            state_r <= S_CP_SEL;
          end else begin
            pass_r  <= 1'b1;
            state_r <= S_POS;
          end
        end
        S_CP_SEL: begin
          if (run_r == 3'd4) begin
            cnt_r   <= '0;
            state_r <= S_RB_RD;
          end else if (len_r[run_r[1:0]] == '0) begin
            run_r <= run_r + 3'd1;
          end else begin
            src_r   <= start_r[run_r[1:0]];
            cnt_r   <= len_r[run_r[1:0]];
            state_r <= S_CP_RD;
          end
        end
        S_CP_RD: state_r <= S_CP_WR;
        S_CP_WR: begin
          k_r   <= k_r + LW'(1);
          src_r <= f_fwd(src_r, n_r);
          cnt_r <= cnt_r - LW'(1);
          if (cnt_r == LW'(1)) begin
            run_r   <= run_r + 3'd1;
            state_r <= S_CP_SEL;
          end else begin
            state_r <= S_CP_RD;
          end
        end
        S_RB_RD: state_r <= S_RB_WR;
        S_RB_WR: begin
          cnt_r <= cnt_r + LW'(1);
          if (cnt_r == n_r - LW'(1)) begin
            cnt_r   <= '0;
            pass_r  <= 1'b1;
            state_r <= S_POS;
          end else begin
            state_r <= S_RB_RD;
          end
        end
        S_NB: begin
          // successor read at count 0, predecessor at count 1
          cnt_r <= cnt_r + LW'(1);
          if (cnt_r == LW'(1)) begin
            succ_r <= ord_q;
          end
          if (cnt_r == LW'(2)) begin
            pred_r  <= ord_q;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
      // a length write restarts the identity sweep
      if (cfg_wr_en) begin
        n_r     <= n_nxt;
        cnt_r   <= '0;
        state_r <= S_CLEAR;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (bad_r) begin
        out_position_a    <= '0;
        out_successor_a   <= '0;
        out_predecessor_a <= '0;
        out_gap_bc        <= '0;
        out_a_between     <= 1'b0;
        out_bad_vertex    <= 1'b1;
      end else begin
        out_position_a    <= 10'(p_r[0]);
        out_successor_a   <= 10'(succ_r);
        out_predecessor_a <= 10'(pred_r);
        out_gap_bc        <= 11'(gap_pos);
        out_a_between     <= ((p_r[1] < p_r[2]) && (p_r[0] > p_r[1]) && (p_r[0] < p_r[2])) ||
                             ((p_r[1] > p_r[2]) && ((p_r[0] > p_r[1]) || (p_r[0] < p_r[2])));
        out_bad_vertex    <= 1'b0;
      end
    end
  end

  // checks
  a_rev_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REV_D) |-> (cnt_r != '0))
    else $error("reverse step count ran out");

  a_rb_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RB_WR) |-> (cnt_r < n_r))
    else $error("rebuild index beyond tour length");

  a_copy_total: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CP_SEL) && (run_r == 3'd4)) |-> (k_r == n_r))
    else $error("segment copy did not fill the tour");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_vertex) |-> ((out_position_a == '0) && (out_gap_bc == '0)))
    else $error("bad vertex result carries data");

endmodule

`default_nettype wire

// ===== sim/cyclic_tour_table_with_reversal_top_tb.sv =====
// ----------------------------------------------------------------------------
// cyclic_tour_table_with_reversal_top_tb: self-checking bench for the tour table
// Drives reverse, swap and query items through several tour lengths, predicts
// every result on a software copy of the order and position tables and
// compares each whole result transfer against the prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module cyclic_tour_table_with_reversal_top_tb
  import cttr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         NMAX       = 1024;
  localparam logic [1:0] OP_SPARE   = 2'd3;   // unused code, acts as query
  localparam int         STALL_MAX  = 12;
  localparam int         LONG_HOLD  = 2000;   // outlasts the clearing pass
  localparam int         IDLE_LIMIT = 40000;
  localparam int         DRAIN_WAIT = 24;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] va, vb, vc, vd;
  } tour_cmd_t;

  typedef struct packed {
    logic [9:0]        pos, succ, pred;
    logic signed [10:0] gap;
    logic              betw, bad;
  } tour_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [10:0] cfg_tour_length = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = '0;
  logic [9:0] in_vert_a = '0, in_vert_b = '0, in_vert_c = '0, in_vert_d = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [9:0] out_position_a, out_successor_a, out_predecessor_a;
  logic signed [10:0] out_gap_bc;
  logic out_a_between, out_bad_vertex;

  cyclic_tour_table_with_reversal_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_tour_length(cfg_tour_length),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_vert_a(in_vert_a), .in_vert_b(in_vert_b),
    .in_vert_c(in_vert_c), .in_vert_d(in_vert_d),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_position_a(out_position_a), .out_successor_a(out_successor_a),
    .out_predecessor_a(out_predecessor_a), .out_gap_bc(out_gap_bc),
    .out_a_between(out_a_between), .out_bad_vertex(out_bad_vertex)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow tour: order (position -> vertex) and inverse
  int tour_ord[NMAX];
  int tour_pos[NMAX];
  int tour_n;

  tour_cmd_t cmd_q[$];
  tour_res_t want_q[$];
  int fail_cnt = 0;
  int n_in = 0, n_out = 0, n_swap = 0, n_rev = 0, n_bad = 0;
  int hold_req = 0, hold_seen = 0;
  bit burst_in = 0, burst_out = 0;

  function automatic void tour_identity(int n);
    for (int i = 0; i < NMAX; i++) begin
      tour_ord[i] = i;
      tour_pos[i] = i;
    end
    tour_n = n;
  endfunction

  function automatic int pos_next(int p);
    return (p + 1 >= tour_n) ? 0 : p + 1;
  endfunction

  function automatic int pos_prev(int p);
    return (p == 0) ? tour_n - 1 : p - 1;
  endfunction

  function automatic int fwd_steps(int p, int q);
    return (q >= p) ? q - p : tour_n - (p - q);
  endfunction

  function automatic int inner_gap(int p, int q);
    return (p > q) ? tour_n - (p - q + 1) : q - p - 1;
  endfunction

  function automatic void reverse_run(int vb, int vc);
    int p, q, d, steps, x, y;
    p = tour_pos[vb];
    q = tour_pos[vc];
    d = inner_gap(p, q);
    steps = (d < 0) ? 1 : d / 2 + 1;
    for (int s = 0; s < steps; s++) begin
      x = tour_ord[p];
      y = tour_ord[q];
      tour_ord[p] = y;
      tour_ord[q] = x;
      tour_pos[y] = p;
      tour_pos[x] = q;
      p = pos_next(p);
      q = pos_prev(q);
    end
  endfunction

  function automatic void swap_runs(int va, int vb, int vc, int vd);
    int buf_v[NMAX];
    int st[4], cnt[4];
    int k, p;
    st[0] = tour_pos[vc];           cnt[0] = fwd_steps(st[0], tour_pos[vd]) + 1;
    st[1] = pos_next(tour_pos[vb]); cnt[1] = fwd_steps(st[1], tour_pos[vc]);
    st[2] = tour_pos[va];           cnt[2] = fwd_steps(st[2], tour_pos[vb]) + 1;
    st[3] = pos_next(tour_pos[vd]); cnt[3] = fwd_steps(st[3], tour_pos[va]);
    if (cnt[0] + cnt[1] + cnt[2] + cnt[3] != tour_n) return;
    k = 0;
    for (int r = 0; r < 4; r++) begin
      p = st[r];
      for (int i = 0; i < cnt[r]; i++) begin
        buf_v[k++] = tour_ord[p];
        p = pos_next(p);
      end
    end
    for (int i = 0; i < k; i++) begin
      tour_ord[i] = buf_v[i];
      tour_pos[buf_v[i]] = i;
    end
  endfunction

  // apply one item to the shadow tour and return its result
  function automatic tour_res_t tour_apply(tour_cmd_t c);
    tour_res_t r;
    int pa, pb, pc, g;
    r = '0;
    if (c.va >= tour_n || c.vb >= tour_n || c.vc >= tour_n ||
        (c.op == OP_SWAP && c.vd >= tour_n)) begin
      r.bad = 1'b1;
      return r;
    end
    if (c.op == OP_REVERSE) reverse_run(c.vb, c.vc);
    else if (c.op == OP_SWAP) swap_runs(c.va, c.vb, c.vc, c.vd);
    pa = tour_pos[c.va];
    pb = tour_pos[c.vb];
    pc = tour_pos[c.vc];
    g = inner_gap(pb, pc);
    r.pos  = pa[9:0];
    r.succ = tour_ord[pos_next(pa)][9:0];
    r.pred = tour_ord[pos_prev(pa)][9:0];
    r.gap  = g[10:0];
    r.betw = (pb < pc && pa > pb && pa < pc) || (pb > pc && (pa > pb || pa < pc));
    return r;
  endfunction

  task automatic queue_cmd(logic [1:0] op, int a, int b, int c, int d);
    tour_cmd_t t;
    t.op = op; t.va = a[9:0]; t.vb = b[9:0]; t.vc = c[9:0]; t.vd = d[9:0];
    if (op == OP_SWAP) n_swap++;
    if (op == OP_REVERSE) n_rev++;
    want_q.push_back(tour_apply(t));
    cmd_q.push_back(t);
  endtask

  function automatic int pick_vertex();
    if (tour_n < NMAX && $urandom_range(0, 15) == 0) return $urandom_range(tour_n, NMAX - 1);
    return $urandom_range(0, tour_n - 1);
  endfunction

  task automatic queue_random();
    int sel, p1, p2, p3, p4, rot;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      queue_cmd(OP_REVERSE, pick_vertex(), pick_vertex(), pick_vertex(), $urandom_range(0, 1023));
    end else if (sel < 65) begin
      if (tour_n >= 2 && $urandom_range(0, 4) != 0) begin
        // well-formed swap: a..b then c..d in forward order, rotated
        p2 = $urandom_range(0, tour_n - 2);
        p3 = $urandom_range(p2 + 1, tour_n - 1);
        p1 = $urandom_range(0, p2);
        p4 = $urandom_range(p3, tour_n - 1);
        rot = $urandom_range(0, tour_n - 1);
        queue_cmd(OP_SWAP, tour_ord[(p1 + rot) % tour_n], tour_ord[(p2 + rot) % tour_n],
                  tour_ord[(p3 + rot) % tour_n], tour_ord[(p4 + rot) % tour_n]);
      end else begin
        queue_cmd(OP_SWAP, pick_vertex(), pick_vertex(), pick_vertex(), pick_vertex());
      end
    end else if (sel < 93) begin
      queue_cmd(OP_QUERY, pick_vertex(), pick_vertex(), pick_vertex(), $urandom_range(0, 1023));
    end else begin
      queue_cmd(OP_SPARE, pick_vertex(), pick_vertex(), pick_vertex(), $urandom_range(0, 1023));
    end
  endtask

  // wait until all queued items are done and the block is quiet
  task automatic wait_drain();
    while (cmd_q.size() != 0 || in_valid || want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_length(int v);
    int eff;
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_tour_length <= v[10:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    eff = (v == 0) ? 1 : (v > NMAX ? NMAX : v);
    tour_identity(eff);
  endtask

  // input driver: holds the item until transfer, then waits a drawn gap
  bit in_xfer = 0;
  int in_wait = 0;
  always @(negedge clk) begin
    logic nv;
    tour_cmd_t t;
    nv = in_valid && !in_xfer;
    if (rst_n && !nv) begin
      if (in_wait > 0) begin
        in_wait--;
      end else if (cmd_q.size() != 0) begin
        t = cmd_q.pop_front();
        in_operation <= t.op;
        in_vert_a <= t.va;
        in_vert_b <= t.vb;
        in_vert_c <= t.vc;
        in_vert_d <= t.vd;
        nv = 1'b1;
        in_wait = burst_in ? 0 : $urandom_range(0, STALL_MAX);
      end
    end
    in_valid <= nv;
  end

  // result receiver: random stalls plus one long hold-off
  bit out_xfer = 0;
  int out_wait = 0;
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      out_wait = LONG_HOLD;
    end else if (out_xfer && out_wait == 0) begin
      out_wait = burst_out ? 0 : $urandom_range(0, STALL_MAX);
    end
    if (out_wait > 0) begin
      out_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n;
    end
  end

  // monitor, checker and watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    tour_res_t got, w;
    in_xfer <= in_valid && in_ready;
    out_xfer <= out_valid && out_ready;
    if (in_valid && in_ready) n_in++;
    if (out_valid && out_ready) begin
      n_out++;
      got = '{out_position_a, out_successor_a, out_predecessor_a, out_gap_bc,
              out_a_between, out_bad_vertex};
      if (want_q.size() == 0) begin
        $display("%0t ERROR: unexpected result transfer %p", $time, got);
        fail_cnt++;
      end else begin
        w = want_q.pop_front();
        if (w.bad) n_bad++;
        if (got !== w) begin
          $display("%0t ERROR: result mismatch expected %p actual %p", $time, w, got);
          fail_cnt++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    int lens[7] = '{0, 2, 7, 2047, 64, 1, 13};
    int cnts[7] = '{8, 30, 60, 10, 90, 10, 60};
    tour_identity(NMAX);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed items on the full-length reset tour
    queue_cmd(OP_QUERY, 0, 0, 1023, 0);
    queue_cmd(OP_QUERY, 1023, 1023, 0, 1023);
    queue_cmd(OP_SPARE, 512, 100, 900, 5);
    queue_cmd(OP_REVERSE, 5, 7, 7, 0);
    queue_cmd(OP_REVERSE, 1, 1000, 5, 0);
    queue_cmd(OP_REVERSE, 300, 0, 1023, 0);
    queue_cmd(OP_SWAP, 10, 20, 30, 40);
    queue_cmd(OP_SWAP, 40, 30, 20, 10);
    queue_cmd(OP_QUERY, 682, 341, 341, 1023);
    wait_drain();

    // small tour: bad vertices, malformed swap and long receiver hold-off
    write_length(5);
    queue_cmd(OP_QUERY, 5, 0, 0, 0);
    queue_cmd(OP_REVERSE, 0, 1023, 1, 0);
    queue_cmd(OP_SWAP, 0, 1, 2, 1023);
    queue_cmd(OP_QUERY, 1, 2, 1023, 0);
    queue_cmd(OP_SWAP, 0, 0, 0, 0);
    queue_cmd(OP_SWAP, 3, 4, 0, 1);
    hold_req++;
    burst_in = 1;
    for (int i = 0; i < 20; i++) queue_random();
    wait_drain();
    burst_in = 0;

    // random phases over several lengths, extremes among them
    for (int ph = 0; ph < 7; ph++) begin
      write_length(lens[ph]);
      for (int i = 0; i < cnts[ph]; i++) begin
        if (i % 25 == 0) begin
          burst_in = ($urandom_range(0, 3) == 0);
          burst_out = ($urandom_range(0, 3) == 0);
        end
        queue_random();
      end
      wait_drain();
    end

    $display("Ran %0d items (%0d reverses, %0d swaps, %0d bad-vertex results)",
             n_in, n_rev, n_swap, n_bad);
    $display("Tour lengths 1 to 1024 covered, %0d results checked", n_out);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/cttr_pkg.sv
src/cyclic_tour_table_with_reversal_top.sv
sim/cyclic_tour_table_with_reversal_top_tb.sv
